>>> design/crrs_pkg.sv
// ----------------------------------------------------------------------------
// crrs_pkg
// Shared codes, field widths and controller/datapath handshake types for the
// container round-robin scheduler.
// ----------------------------------------------------------------------------
package crrs_pkg;

  localparam int CMD_W = 2;
  localparam int KEY_W = 32;
  localparam int TID_W = 16;
  localparam int ST_W  = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWITCH = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // latch the accepted beat and restart the slot scan
    logic scan_step;  // advance the slot scan address
    logic scan_eval;  // compare the slot read out this cycle
    logic exec;       // apply the update decided by the scan
    logic ring_done;  // ring read data is back, finish the head update
    logic out_load;   // move the result into the output register
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // the slot under compare matches
    logic last;       // the slot under compare is the last one
    logic need_read;  // the update needs the next head from the ring
  } dp_stat_t;

endpackage

>>> design/crrs_if.sv
// ----------------------------------------------------------------------------
// crrs_if
// Valid/ready channels of the scheduler: the command channel and the result
// channel.
// ----------------------------------------------------------------------------
interface crrs_cmd_if import crrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [KEY_W-1:0] container_id;
  logic [TID_W-1:0] thread_id;

  modport source (output valid, output command, output container_id, output thread_id,
                  input ready);
  modport sink   (input valid, input command, input container_id, input thread_id,
                  output ready);
endinterface

interface crrs_res_if import crrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic             caller_sleeps;
  logic             wake_valid;
  logic [TID_W-1:0] wake_thread;

  modport source (output valid, output status, output caller_sleeps, output wake_valid,
                  output wake_thread, input ready);
  modport sink   (input valid, input status, input caller_sleeps, input wake_valid,
                  input wake_thread, output ready);
endinterface

>>> design/container_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// container_round_robin_scheduler
// Round-robin run queue over a table of containers, each holding a FIFO ring
// of thread ids of which only the head runs.
// ----------------------------------------------------------------------------
// The block takes one command beat at a time (create, delete or switch) and
// returns exactly one result beat for it. A command is taken only while the
// block is idle. The slot table lives in a memory with a single read port,
// so the lookup walks it one slot per cycle from slot 0 and stops at the
// first match, or walks every slot when nothing matches (and always for an
// unknown command). A delete or switch that wakes a thread adds a ring read
// before the result. The result sits in an output register, so a new command
// may be accepted while the previous result still waits to be taken. Slot
// validity is kept in flip-flops that reset clears, so no clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module container_round_robin_scheduler import crrs_pkg::*; #(
  parameter int CONTAINERS            = 16,
  parameter int THREADS_PER_CONTAINER = 16
) (
  input  logic       clk,
  input  logic       rst,
  crrs_cmd_if.sink   cmd,
  crrs_res_if.source res
);

  // Command and status buses between the sequencer and the datapath.
  ctl_cmd_t ctl;
  dp_stat_t stat;

  // The sequencer owns the handshakes: it accepts a beat in its idle state
  // and owns the valid flag of the output register.
  crrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // The datapath holds the slot table, the thread rings and the result
  // payload register.
  crrs_dp #(
    .CONTAINERS            (CONTAINERS),
    .THREADS_PER_CONTAINER (THREADS_PER_CONTAINER)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .stat              (stat),
    .in_command        (cmd.command),
    .in_container_id   (cmd.container_id),
    .in_thread_id      (cmd.thread_id),
    .out_status        (res.status),
    .out_caller_sleeps (res.caller_sleeps),
    .out_wake_valid    (res.wake_valid),
    .out_wake_thread   (res.wake_thread)
  );

endmodule

>>> design/crrs_ctrl.sv
// ----------------------------------------------------------------------------
// crrs_ctrl
// Sequencer of the scheduler: accept, slot scan, update, ring read, result.
// ----------------------------------------------------------------------------
module crrs_ctrl import crrs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctl_cmd_t  ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIME,
    S_SCAN,
    S_EXEC,
    S_RING,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE:  ctl.load = in_valid;
      S_PRIME: ctl.scan_step = 1'b1;
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        ctl.scan_eval = 1'b1;
      end
      S_EXEC:  ctl.exec = 1'b1;
      S_RING:  ctl.ring_done = 1'b1;
      S_DONE:  ctl.out_load = out_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_PRIME;
        S_PRIME: state <= S_SCAN;
        S_SCAN:  if (stat.hit || stat.last) state <= S_EXEC;
        S_EXEC:  state <= stat.need_read ? S_RING : S_DONE;
        S_RING:  state <= S_DONE;
        S_DONE:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/crrs_dp.sv
// ----------------------------------------------------------------------------
// crrs_dp
// Datapath of the scheduler: slot table memory, ring memory, scan compare,
// update logic and the result register.
// ----------------------------------------------------------------------------
module crrs_dp import crrs_pkg::*; #(
  parameter int CONTAINERS            = 16,
  parameter int THREADS_PER_CONTAINER = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         ctl,
  output dp_stat_t         stat,
  input  logic [CMD_W-1:0] in_command,
  input  logic [KEY_W-1:0] in_container_id,
  input  logic [TID_W-1:0] in_thread_id,
  output logic [ST_W-1:0]  out_status,
  output logic             out_caller_sleeps,
  output logic             out_wake_valid,
  output logic [TID_W-1:0] out_wake_thread
);

  localparam int SLOT_W = (CONTAINERS > 1) ? $clog2(CONTAINERS) : 1;
  localparam int SCAN_W = $clog2(CONTAINERS + 1);
  localparam int POS_W  = $clog2(THREADS_PER_CONTAINER);
  localparam int SUM_W  = POS_W + 1;
  localparam int CNT_W  = $clog2(THREADS_PER_CONTAINER + 1);
  localparam int CELLS  = CONTAINERS * THREADS_PER_CONTAINER;
  localparam int ADDR_W = $clog2(CELLS);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] front;
    logic [CNT_W-1:0] count;
    logic [TID_W-1:0] head;   // copy of the ring entry at front
  } slot_t;

  // Latched command beat.
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [TID_W-1:0] tid_q;

  // Slot table.
  slot_t                 slot_mem [CONTAINERS];
  slot_t                 slot_rd;
  logic [CONTAINERS-1:0] slot_valid;
  logic [SCAN_W-1:0]     scan_idx;
  logic [SLOT_W-1:0]     cmp_idx;

  // Scan results.
  logic              found;
  slot_t             sel;
  logic [SLOT_W-1:0] sel_idx;
  logic [ADDR_W-1:0] sel_base;
  logic [POS_W-1:0]  pos_tail;
  logic [POS_W-1:0]  pos_next;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [ADDR_W-1:0] free_base;

  // Ring store.
  logic [TID_W-1:0]  ring_mem [CELLS];
  logic [TID_W-1:0]  ring_rd;
  logic [ADDR_W-1:0] ring_ra;

  // Result.
  logic [ST_W-1:0]  res_status;
  logic             res_sleep;
  logic             res_wake_v;
  logic [TID_W-1:0] res_wake_t;

  // Compare and position logic.
  logic              cmp_valid;
  logic              key_hit;
  logic              head_hit;
  logic [ADDR_W-1:0] cmp_base;
  logic [SUM_W-1:0]  tail_sum;
  logic [POS_W-1:0]  tail_pos;
  logic [POS_W-1:0]  next_pos;
  logic              full;
  logic              lone;

  // Update controls.
  logic              ring_we;
  logic [ADDR_W-1:0] ring_wa;
  logic [TID_W-1:0]  ring_wd;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_wa;
  slot_t             slot_wd;
  logic              valid_set;
  logic              valid_clr;
  logic [ST_W-1:0]   nx_status;
  logic              nx_sleep;

  assign cmp_valid = slot_valid[cmp_idx];
  assign key_hit   = cmp_valid && (cmd_q == CMD_CREATE || cmd_q == CMD_DELETE) &&
                     (slot_rd.key == key_q);
  assign head_hit  = cmp_valid && (cmd_q == CMD_SWITCH) && (slot_rd.head == tid_q);
  assign cmp_base  = ADDR_W'(cmp_idx) * ADDR_W'(THREADS_PER_CONTAINER);

  assign tail_sum  = SUM_W'(slot_rd.front) + SUM_W'(slot_rd.count);
  assign tail_pos  = (tail_sum >= SUM_W'(THREADS_PER_CONTAINER)) ?
                     POS_W'(tail_sum - SUM_W'(THREADS_PER_CONTAINER)) : POS_W'(tail_sum);
  assign next_pos  = (slot_rd.front == POS_W'(THREADS_PER_CONTAINER - 1)) ?
                     '0 : slot_rd.front + POS_W'(1);

  assign full = (sel.count == CNT_W'(THREADS_PER_CONTAINER));
  assign lone = (sel.count == CNT_W'(1));

  assign stat.hit       = key_hit || head_hit;
  assign stat.last      = (cmp_idx == SLOT_W'(CONTAINERS - 1));
  assign stat.need_read = found && !lone && (cmd_q == CMD_DELETE || cmd_q == CMD_SWITCH);

  assign ring_ra = sel_base + ADDR_W'(pos_next);

  always_comb begin
    ring_we   = 1'b0;
    ring_wa   = sel_base + ADDR_W'(pos_tail);
    ring_wd   = tid_q;
    slot_we   = 1'b0;
    slot_wa   = sel_idx;
    slot_wd   = sel;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    nx_status = ST_NOT_FOUND;
    nx_sleep  = 1'b0;
    if (ctl.exec) begin
      case (cmd_q)
        CMD_CREATE: begin
          if (found) begin
            if (full) begin
              nx_status = ST_FULL;
            end else begin
              ring_we       = 1'b1;
              slot_we       = 1'b1;
              slot_wd.count = sel.count + CNT_W'(1);
              nx_status     = ST_DONE;
              nx_sleep      = 1'b1;
            end
          end else if (free_found) begin
            ring_we       = 1'b1;
            ring_wa       = free_base;
            slot_we       = 1'b1;
            slot_wa       = free_idx;
            slot_wd.key   = key_q;
            slot_wd.front = '0;
            slot_wd.count = CNT_W'(1);
            slot_wd.head  = tid_q;
            valid_set     = 1'b1;
            nx_status     = ST_DONE;
          end else begin
            nx_status = ST_FULL;
          end
        end
        CMD_DELETE: begin
          if (found) begin
            nx_status = ST_DONE;
            valid_clr = lone;
          end
        end
        CMD_SWITCH: begin
          if (found) begin
            nx_status = ST_DONE;
            if (!lone) begin
              ring_we  = 1'b1;
              nx_sleep = 1'b1;
            end
          end
        end
        default: nx_status = ST_NOT_FOUND;
      endcase
    end else if (ctl.ring_done) begin
      slot_we       = 1'b1;
      slot_wd.front = pos_next;
      slot_wd.head  = ring_rd;
      if (cmd_q == CMD_DELETE) begin
        slot_wd.count = sel.count - CNT_W'(1);
      end
    end
  end

  // Slot table memory: one write port, scan read port.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[scan_idx[SLOT_W-1:0]];
    cmp_idx <= scan_idx[SLOT_W-1:0];
  end

  // Ring memory: one write port, one read port.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_wa] <= ring_wd;
    end
    ring_rd <= ring_mem[ring_ra];
  end

  // Control state: valid bits, scan address and scan flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      scan_idx   <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (valid_set) begin
        slot_valid[free_idx] <= 1'b1;
      end else if (valid_clr) begin
        slot_valid[sel_idx] <= 1'b0;
      end
      if (ctl.load) begin
        scan_idx   <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (ctl.scan_step) begin
          scan_idx <= scan_idx + SCAN_W'(1);
        end
        if (ctl.scan_eval) begin
          if (stat.hit) begin
            found <= 1'b1;
          end
          if (!cmp_valid && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q <= in_command;
      key_q <= in_container_id;
      tid_q <= in_thread_id;
    end
    if (ctl.scan_eval) begin
      if (stat.hit) begin
        sel      <= slot_rd;
        sel_idx  <= cmp_idx;
        sel_base <= cmp_base;
        pos_tail <= tail_pos;
        pos_next <= next_pos;
      end
      if (!cmp_valid && !free_found) begin
        free_idx  <= cmp_idx;
        free_base <= cmp_base;
      end
    end
    if (ctl.exec) begin
      res_status <= nx_status;
      res_sleep  <= nx_sleep;
      res_wake_v <= 1'b0;
      res_wake_t <= '0;
    end else if (ctl.ring_done) begin
      res_wake_v <= 1'b1;
      res_wake_t <= ring_rd;
    end
    if (ctl.out_load) begin
      out_status        <= res_status;
      out_caller_sleeps <= res_sleep;
      out_wake_valid    <= res_wake_v;
      out_wake_thread   <= res_wake_t;
    end
  end

endmodule

>>> design/crrs_checker.sv
// ----------------------------------------------------------------------------
// crrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module crrs_checker import crrs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic [ST_W-1:0]  status,
  input logic             caller_sleeps,
  input logic             wake_valid,
  input logic [TID_W-1:0] wake_thread
);

  // A pending result stays until it is taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped before it was taken");

  // Only one command is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command accepted while another is in work");

  // The wake thread reads zero when no thread is woken.
  a_wake_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !wake_valid |-> wake_thread == '0)
    else $error("wake thread not zero without a wake");

  // Sleeping the caller only happens on a successful command.
  a_sleep_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && caller_sleeps |-> status == ST_DONE)
    else $error("caller put to sleep on a failed command");

  // A wake only happens on a successful command.
  a_wake_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && wake_valid |-> status == ST_DONE)
    else $error("thread woken on a failed command");

endmodule

bind container_round_robin_scheduler crrs_checker u_crrs_checker (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .status        (res.status),
  .caller_sleeps (res.caller_sleeps),
  .wake_valid    (res.wake_valid),
  .wake_thread   (res.wake_thread)
);

>>> tb/tb_container_round_robin_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_container_round_robin_scheduler
// Self-checking bench for the container round-robin scheduler. Command beats
// go in through the command channel. A scoreboard model of the slot table and
// the thread rings predicts the result beat of every accepted command. Each
// result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_container_round_robin_scheduler import crrs_pkg::*;;

  localparam int CONTAINERS = 16;
  localparam int RING_LEN   = 16;
  localparam int HEAD_W     = $clog2(RING_LEN);
  localparam int DEPTH_W    = $clog2(RING_LEN + 1);
  localparam int KEY_POOL   = 24;
  localparam int TID_POOL   = 8;

  // The package names only the three real commands. The fourth encoding must
  // also be exercised, and the block reports it as not found.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // The slowest command walks all slots and then wakes a thread. The drain
  // wait at the end covers it with margin.
  localparam int DRAIN_CYCLES   = 4 + CONTAINERS + 1 + 12;
  // A silent stretch is at most one slow command plus the longest sender gap
  // and the longest result stall. The limit is many times that.
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             sleeps;
    logic             wake;
    logic [TID_W-1:0] wake_tid;
  } sched_result_t;

  logic clk;
  logic rst;

  crrs_cmd_if cmd_if ();
  crrs_res_if res_if ();

  container_round_robin_scheduler #(
    .CONTAINERS            (CONTAINERS),
    .THREADS_PER_CONTAINER (RING_LEN)
  ) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  // Scoreboard copy of the scheduler state.
  logic               occupied [CONTAINERS];
  logic [KEY_W-1:0]   cont_id  [CONTAINERS];
  logic [HEAD_W-1:0]  head_pos [CONTAINERS];
  logic [DEPTH_W-1:0] depth    [CONTAINERS];
  logic [TID_W-1:0]   ring_tid [CONTAINERS][RING_LEN];

  sched_result_t    expected_results[$];
  sched_result_t    oldest;
  logic [KEY_W-1:0] key_pool [KEY_POOL];
  logic [TID_W-1:0] tid_pool [TID_POOL];

  int mismatches   = 0;
  int stall_left   = 0;
  int quiet_cycles = 0;
  bit calm_tail    = 1'b0;  // set for the last part of the run: no idling at all

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------

  // Create and delete act on the lowest live slot that carries the id.
  function automatic int find_container(input logic [KEY_W-1:0] key);
    for (int i = 0; i < CONTAINERS; i++) begin
      if (occupied[i] && depth[i] != 0 && cont_id[i] == key) return i;
    end
    return -1;
  endfunction

  // Applies one command to the model and returns the result beat that the
  // block must send for it. Every path yields exactly one result.
  function automatic sched_result_t predict_schedule(input logic [CMD_W-1:0] op,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [TID_W-1:0] tid);
    sched_result_t r;
    int            s;
    r        = '0;
    r.status = ST_NOT_FOUND;
    case (op)
      CMD_CREATE: begin
        s = find_container(key);
        if (s >= 0) begin
          // A full ring refuses the caller, who then keeps running.
          if (depth[s] >= RING_LEN) begin
            r.status = ST_FULL;
          end else begin
            ring_tid[s][(int'(head_pos[s]) + int'(depth[s])) % RING_LEN] = tid;
            depth[s] = depth[s] + 1'b1;
            r.status = ST_DONE;
            r.sleeps = 1'b1;
          end
        end else begin
          // A new id takes the lowest free slot with the caller running.
          r.status = ST_FULL;
          for (int i = 0; i < CONTAINERS; i++) begin
            if (!occupied[i]) begin
              occupied[i]    = 1'b1;
              cont_id[i]     = key;
              head_pos[i]    = '0;
              depth[i]       = 1;
              ring_tid[i][0] = tid;
              r.status       = ST_DONE;
              break;
            end
          end
        end
      end
      CMD_DELETE: begin
        // The head is popped no matter who the caller is.
        s = find_container(key);
        if (s >= 0) begin
          head_pos[s] = HEAD_W'((int'(head_pos[s]) + 1) % RING_LEN);
          depth[s]    = depth[s] - 1'b1;
          r.status    = ST_DONE;
          if (depth[s] != 0) begin
            r.wake     = 1'b1;
            r.wake_tid = ring_tid[s][head_pos[s]];
          end else begin
            occupied[s] = 1'b0;
            head_pos[s] = '0;
          end
        end
      end
      CMD_SWITCH: begin
        // Only the lowest slot that the caller heads is rotated. A lone
        // thread just keeps running.
        for (int i = 0; i < CONTAINERS; i++) begin
          if (occupied[i] && depth[i] != 0 && ring_tid[i][head_pos[i]] == tid) begin
            r.status = ST_DONE;
            if (depth[i] > 1) begin
              ring_tid[i][(int'(head_pos[i]) + int'(depth[i])) % RING_LEN] = tid;
              head_pos[i] = HEAD_W'((int'(head_pos[i]) + 1) % RING_LEN);
              r.sleeps    = 1'b1;
              r.wake      = 1'b1;
              r.wake_tid  = ring_tid[i][head_pos[i]];
            end
            break;
          end
        end
      end
      default: begin
        r.status = ST_NOT_FOUND;
      end
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------

  // Sends one command beat. The task is entered and left at a falling edge.
  // Before the beat there may be an idle burst. The prediction is queued at
  // the rising edge that accepts the beat.
  task automatic issue_command(input logic [CMD_W-1:0] op,
                               input logic [KEY_W-1:0] key,
                               input logic [TID_W-1:0] tid);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.command      <= op;
    cmd_if.container_id <= key;
    cmd_if.thread_id    <= tid;
    do @(posedge clk); while (!cmd_if.ready);
    expected_results.push_back(predict_schedule(op, key, tid));
    @(negedge clk);
  endtask

  // Picks a random live slot, or returns -1 when the table is empty.
  function automatic int live_slot();
    int start;
    start = $urandom_range(0, CONTAINERS - 1);
    for (int i = 0; i < CONTAINERS; i++) begin
      if (occupied[(start + i) % CONTAINERS]) return (start + i) % CONTAINERS;
    end
    return -1;
  endfunction

  // A random command. Ids mostly come from a small pool so that containers
  // fill up, and most deletes and switches aim at live containers and current
  // heads. The rest is noise that misses.
  task automatic random_command(input int create_pct, input int delete_pct,
                                input int key_span);
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [TID_W-1:0] tid;
    int               roll;
    int               pick;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      op = CMD_UNUSED;
    end else if (roll < create_pct) begin
      op = CMD_CREATE;
    end else if (roll < create_pct + delete_pct) begin
      op = CMD_DELETE;
    end else begin
      op = CMD_SWITCH;
    end
    if ($urandom_range(0, 9) == 0) begin
      key = $urandom;
    end else begin
      key = key_pool[$urandom_range(0, key_span - 1)];
    end
    if ($urandom_range(0, 9) < 3) begin
      tid = TID_W'($urandom_range(0, 65535));
    end else begin
      tid = tid_pool[$urandom_range(0, TID_POOL - 1)];
    end
    pick = live_slot();
    if (pick >= 0 && $urandom_range(0, 99) < 80) begin
      if (op == CMD_DELETE) key = cont_id[pick];
      if (op == CMD_SWITCH) tid = ring_tid[pick][head_pos[pick]];
    end
    issue_command(op, key, tid);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-written sequence over the extremes of the id fields, every command,
  // the unused encoding, and the corner cases. These are: a miss on an empty
  // table, a switch by a lone thread, a switch by a thread that is not a head,
  // a thread that heads two containers, a delete by a caller that is not the
  // head, a container emptied and freed, and a freed slot taken again.
  task automatic test_directed_cases();
    logic [KEY_W-1:0] k_low;
    logic [KEY_W-1:0] k_high;
    k_low  = '0;
    k_high = '1;
    issue_command(CMD_DELETE, k_low, 16'h0000);
    issue_command(CMD_SWITCH, k_high, 16'hFFFF);
    issue_command(CMD_UNUSED, k_high, 16'hFFFF);
    issue_command(CMD_CREATE, k_low, 16'h0000);
    issue_command(CMD_SWITCH, k_low, 16'h0000);
    issue_command(CMD_CREATE, k_low, 16'hFFFF);
    issue_command(CMD_CREATE, k_low, 16'h0001);
    issue_command(CMD_SWITCH, k_low, 16'hFFFF);
    issue_command(CMD_SWITCH, k_high, 16'h0000);
    // From here on 16'hFFFF heads both containers, and the lower slot rotates.
    issue_command(CMD_CREATE, k_high, 16'hFFFF);
    issue_command(CMD_SWITCH, 32'h5A5A_A5A5, 16'hFFFF);
    issue_command(CMD_DELETE, k_low, 16'h1234);
    issue_command(CMD_DELETE, k_low, 16'hFFFF);
    issue_command(CMD_DELETE, k_low, 16'h0000);
    issue_command(CMD_DELETE, k_low, 16'h0000);
    issue_command(CMD_CREATE, k_low, 16'hAAAA);
    issue_command(CMD_DELETE, k_high, 16'h5555);
    issue_command(CMD_UNUSED, k_low, 16'h0000);
    issue_command(CMD_CREATE, k_high, 16'h5555);
    issue_command(CMD_SWITCH, k_low, 16'h5555);
  endtask

  // Few ids and mostly creates, so that rings run full and wrap around.
  task automatic test_ring_fill();
    repeat (300) random_command(70, 12, 3);
  endtask

  // Many ids and mostly creates, so that the slot table runs full.
  task automatic test_table_fill();
    repeat (300) random_command(65, 15, KEY_POOL);
  endtask

  // A balanced mix that rotates deep rings and empties containers again.
  task automatic test_mixed_traffic();
    repeat (450) random_command(40, 30, KEY_POOL);
  endtask

  // Back-to-back beats on both channels with no idling.
  task automatic test_back_to_back();
    calm_tail = 1'b1;
    repeat (200) random_command(40, 30, 8);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // The result channel stalls in sparse bursts, which also leaves long
  // stretches with ready held high.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
      res_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 10);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Each accepted result beat is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual %0h/%0h/%0h/%0h",
                 $time, res_if.status, res_if.caller_sleeps, res_if.wake_valid,
                 res_if.wake_thread);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("status", oldest.status, res_if.status);
        check_field("caller_sleeps", oldest.sleeps, res_if.caller_sleeps);
        check_field("wake_valid", oldest.wake, res_if.wake_valid);
        check_field("wake_thread", oldest.wake_tid, res_if.wake_thread);
      end
    end
  end

  // The watchdog ends a run in which no beat moves on either channel for too
  // long.
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_container_round_robin_scheduler: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    cmd_if.valid        = 1'b0;
    cmd_if.command      = CMD_CREATE;
    cmd_if.container_id = '0;
    cmd_if.thread_id    = '0;
    res_if.ready        = 1'b0;
    for (int i = 0; i < CONTAINERS; i++) begin
      occupied[i] = 1'b0;
      head_pos[i] = '0;
      depth[i]    = '0;
    end
    // The pools hold the all-zero and all-one values beside random ones.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    tid_pool[0] = '0;
    tid_pool[1] = '1;
    for (int i = 2; i < TID_POOL; i++) tid_pool[i] = TID_W'($urandom_range(0, 65535));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_cases();
    test_ring_fill();
    test_table_fill();
    test_mixed_traffic();
    test_back_to_back();
    cmd_if.valid <= 1'b0;

    // Every prediction must be met, and no stray result may follow.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_container_round_robin_scheduler: done, clean");
    end else begin
      $display("tb_container_round_robin_scheduler: done, errors");
    end
    $finish;
  end

endmodule
